// File: rtl/core/svc_pkg.sv
// Shared types, constants and widths for the silhouette voxel carver.
// No dependencies; every other file but svc_if imports this package.
package svc_pkg;

  // Grid and image geometry
  localparam int GRID_DIM   = 64;
  localparam int GRID_CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int GRID_AW    = $clog2(GRID_CELLS);
  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 512;
  localparam int PIX_DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int PIX_AW     = $clog2(PIX_DEPTH);
  localparam int MAX_DIM    = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int QW         = $clog2(MAX_DIM);

  // Datapath widths
  localparam int LIM_W = 16;
  localparam int PROD_W = 62;
  localparam int SUM_W = 66;
  localparam int MAG_W = SUM_W;
  localparam int REM_W = MAG_W + QW;
  localparam int VAL_W = 17;
  localparam int CFG_IW = 3;
  localparam int MAT_ENTRIES = 12;

  localparam logic signed [VAL_W-1:0] CLEAR_VALUE = 17'sd16000;
  localparam logic signed [VAL_W-1:0] MISS_VALUE  = -17'sd16;

  // Item kinds
  localparam logic [1:0] KIND_COEF  = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_CARVE = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // Register indexes
  localparam logic [CFG_IW-1:0] CFG_START_X = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_START_Y = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_START_Z = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_STEP_X  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_STEP_Y  = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_STEP_Z  = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_COLS    = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_ROWS    = 3'd7;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic [30:0]        step_x;
    logic [30:0]        step_y;
    logic [30:0]        step_z;
    logic [10:0]        image_cols;
    logic [9:0]         image_rows;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               vox_ok;
    logic [GRID_AW-1:0] gaddr;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic [9:0]         pixel_col;
    logic [8:0]         pixel_row;
    logic [15:0]        pixel_distance;
    logic               pixel_inside;
  } meta_t;

  typedef struct packed {
    logic             valid;
    meta_t            meta;
    logic             sn0;
    logic             sn1;
    logic             sd;
    logic             dz;
    logic [MAG_W-1:0] mag0;
    logic [MAG_W-1:0] mag1;
    logic [MAG_W-1:0] dmag;
  } proj_t;

  typedef struct packed {
    logic             valid;
    meta_t            meta;
    logic             sn0;
    logic             sn1;
    logic             sd;
    logic             dz;
    logic             ov0;
    logic             ov1;
    logic [MAG_W-1:0] dmag;
    logic [REM_W-1:0] r0;
    logic [REM_W-1:0] r1;
    logic [QW-1:0]    q0;
    logic [QW-1:0]    q1;
  } dstage_t;

  typedef struct packed {
    logic adv;
    logic clearing;
  } status_t;

endpackage

// File: rtl/core/svc_if.sv
// Valid/ready channel interfaces for input items and result items.
interface svc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  coef_index;
  logic signed [31:0] coef_value;
  logic [9:0]  pixel_col;
  logic [8:0]  pixel_row;
  logic [15:0] pixel_distance;
  logic        pixel_inside;
  logic [5:0]  voxel_x;
  logic [5:0]  voxel_y;
  logic [5:0]  voxel_z;

  modport source(output valid, kind, coef_index, coef_value, pixel_col, pixel_row,
                 pixel_distance, pixel_inside, voxel_x, voxel_y, voxel_z, input ready);
  modport sink(input valid, kind, coef_index, coef_value, pixel_col, pixel_row,
               pixel_distance, pixel_inside, voxel_x, voxel_y, voxel_z, output ready);
endinterface

interface svc_out_if;
  logic        valid;
  logic        ready;
  logic [17:0] voxel_address;
  logic signed [16:0] voxel_value;
  logic        in_view;
  logic        updated;

  modport source(output valid, voxel_address, voxel_value, in_view, updated, input ready);
  modport sink(input valid, voxel_address, voxel_value, in_view, updated, output ready);
endinterface

// File: rtl/core/silhouette_voxel_carver.sv
// Top level of the silhouette voxel carver: configuration registers and the
// three pipeline sections. Depends on svc_pkg, svc_if, svc_proj, svc_div, svc_carve.
//
// One item enters per clock cycle when the result side keeps up; every item,
// load or voxel, flows through the same pipeline of 5 + (QW+1) + 4 register
// stages, the QW+1 of them making up the one-bit-per-stage column/row
// divider. Loads update the matrix and the pixel memory at the pipeline stage
// that reads them, so items apply strictly in order. A stalled result holds
// the whole pipeline. After reset the grid is cleared to 1000.0 in a pass over
// all GRID_DIM^3 cells, during which no item is accepted; configuration
// writes are taken at any time.
module silhouette_voxel_carver (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [svc_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]                cfg_data,
  svc_in_if.sink                     items,
  svc_out_if.source                  results
);
  import svc_pkg::*;

  cfg_t    cfg;
  status_t st;
  proj_t   po;
  dstage_t dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_x    <= '0;
      cfg.start_y    <= '0;
      cfg.start_z    <= '0;
      cfg.step_x     <= 31'd65536;
      cfg.step_y     <= 31'd65536;
      cfg.step_z     <= 31'd65536;
      cfg.image_cols <= 11'd640;
      cfg.image_rows <= 10'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_X: cfg.start_x    <= cfg_data;
        CFG_START_Y: cfg.start_y    <= cfg_data;
        CFG_START_Z: cfg.start_z    <= cfg_data;
        CFG_STEP_X:  cfg.step_x     <= cfg_data[30:0];
        CFG_STEP_Y:  cfg.step_y     <= cfg_data[30:0];
        CFG_STEP_Z:  cfg.step_z     <= cfg_data[30:0];
        CFG_COLS:    cfg.image_cols <= cfg_data[10:0];
        CFG_ROWS:    cfg.image_rows <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  svc_proj u_proj (
    .clk   (clk),
    .rst   (rst),
    .st    (st),
    .cfg   (cfg),
    .items (items),
    .po    (po)
  );

  svc_div u_div (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .pi  (po),
    .dq  (dq)
  );

  svc_carve u_carve (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .dq      (dq),
    .st      (st),
    .results (results)
  );

endmodule

// File: rtl/core/svc_proj.sv
// Front of the pipeline: input register, world position, matrix products,
// row sums and magnitudes for the divider. Depends on svc_pkg and svc_if.
module svc_proj (
  input  logic            clk,
  input  logic            rst,
  input  svc_pkg::status_t st,
  input  svc_pkg::cfg_t   cfg,
  svc_in_if.sink          items,
  output svc_pkg::proj_t  po
);
  import svc_pkg::*;

  logic v0, v1, v2, v3;
  meta_t m0, m1, m2, m3;
  logic [5:0] x0, y0, z0;
  logic signed [31:0] p1 [3];
  logic signed [31:0] mat [MAT_ENTRIES];
  logic signed [PROD_W-1:0] pr [3][3];
  logic signed [31:0] c3 [3];
  logic signed [SUM_W-1:0] n3 [3];
  logic signed [31:0] start [3];
  logic [30:0] stepv [3];
  logic [5:0] idx [3];
  logic signed [31:0] pos_next [3];
  meta_t min;
  logic acc;

  assign items.ready = st.adv && !st.clearing;
  assign acc = items.valid && items.ready;

  always_comb begin
    min.kind           = items.kind;
    min.vox_ok         = (LIM_W'(items.voxel_x) < LIM_W'(GRID_DIM)) &&
                         (LIM_W'(items.voxel_y) < LIM_W'(GRID_DIM)) &&
                         (LIM_W'(items.voxel_z) < LIM_W'(GRID_DIM));
    min.gaddr          = GRID_AW'(items.voxel_x) * GRID_AW'(GRID_DIM * GRID_DIM) +
                         GRID_AW'(items.voxel_y) * GRID_AW'(GRID_DIM) +
                         GRID_AW'(items.voxel_z);
    min.coef_index     = items.coef_index;
    min.coef_value     = items.coef_value;
    min.pixel_col      = items.pixel_col;
    min.pixel_row      = items.pixel_row;
    min.pixel_distance = items.pixel_distance;
    min.pixel_inside   = items.pixel_inside;
  end

  // Stage 0: input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (st.adv) begin
      v0 <= acc;
    end
    if (st.adv) begin
      m0 <= min;
      x0 <= items.voxel_x;
      y0 <= items.voxel_y;
      z0 <= items.voxel_z;
    end
  end

  // Stage 1: position = start + index * step, saturated to 32 bits
  assign start[0] = cfg.start_x;
  assign start[1] = cfg.start_y;
  assign start[2] = cfg.start_z;
  assign stepv[0] = cfg.step_x;
  assign stepv[1] = cfg.step_y;
  assign stepv[2] = cfg.step_z;
  assign idx[0] = x0;
  assign idx[1] = y0;
  assign idx[2] = z0;

  always_comb begin
    logic [36:0] m;
    logic signed [38:0] s;
    for (int a = 0; a < 3; a++) begin
      m = 37'(idx[a]) * 37'(stepv[a]);
      s = 39'(start[a]) + $signed({2'b00, m});
      if (s[38:31] != {8{s[38]}}) begin
        pos_next[a] = s[38] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        pos_next[a] = s[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (st.adv) begin
      v1 <= v0;
    end
    if (st.adv) begin
      m1 <= m0;
      for (int a = 0; a < 3; a++) p1[a] <= pos_next[a];
    end
  end

  // Coefficient loads land here, in order with the carves that read them
  always_ff @(posedge clk) begin
    if (st.adv && v1 && m1.kind == KIND_COEF && m1.coef_index < 4'(MAT_ENTRIES)) begin
      mat[m1.coef_index] <= m1.coef_value;
    end
  end

  // Stage 2: products, each floored by four
  always_ff @(posedge clk) begin
    logic signed [63:0] full;
    if (rst) begin
      v2 <= 1'b0;
    end else if (st.adv) begin
      v2 <= v1;
    end
    if (st.adv) begin
      m2 <= m1;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          full = mat[r*4+c] * p1[c];
          pr[r][c] <= full[63:2];
        end
        c3[r] <= mat[r*4+3];
      end
    end
  end

  // Stage 3: row sums
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (st.adv) begin
      v3 <= v2;
    end
    if (st.adv) begin
      m3 <= m2;
      for (int r = 0; r < 3; r++) begin
        n3[r] <= SUM_W'(pr[r][0]) + SUM_W'(pr[r][1]) + SUM_W'(pr[r][2]) +
                 (SUM_W'(c3[r]) <<< 14);
      end
    end
  end

  // Stage 4: signs and magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      po.valid <= 1'b0;
    end else if (st.adv) begin
      po.valid <= v3;
    end
    if (st.adv) begin
      po.meta <= m3;
      po.sn0  <= n3[0][SUM_W-1];
      po.sn1  <= n3[1][SUM_W-1];
      po.sd   <= n3[2][SUM_W-1];
      po.dz   <= (n3[2] == '0);
      po.mag0 <= n3[0][SUM_W-1] ? MAG_W'(-n3[0]) : MAG_W'(n3[0]);
      po.mag1 <= n3[1][SUM_W-1] ? MAG_W'(-n3[1]) : MAG_W'(n3[1]);
      po.dmag <= n3[2][SUM_W-1] ? MAG_W'(-n3[2]) : MAG_W'(n3[2]);
    end
  end

endmodule

// File: rtl/core/svc_div.sv
// Pipelined restoring divider for column and row, one quotient bit per stage,
// with an overflow check in front. Depends on svc_pkg.
module svc_div (
  input  logic             clk,
  input  logic             rst,
  input  svc_pkg::status_t st,
  input  svc_pkg::proj_t   pi,
  output svc_pkg::dstage_t dq
);
  import svc_pkg::*;

  dstage_t s [QW+1];
  logic [REM_W-1:0] dtop;

  assign dtop = REM_W'(pi.dmag) << QW;

  // Overflow stage: quotient would not fit in QW bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s[0].valid <= 1'b0;
    end else if (st.adv) begin
      s[0].valid <= pi.valid;
    end
    if (st.adv) begin
      s[0].meta <= pi.meta;
      s[0].sn0  <= pi.sn0;
      s[0].sn1  <= pi.sn1;
      s[0].sd   <= pi.sd;
      s[0].dz   <= pi.dz;
      s[0].ov0  <= REM_W'(pi.mag0) >= dtop;
      s[0].ov1  <= REM_W'(pi.mag1) >= dtop;
      s[0].dmag <= pi.dmag;
      s[0].r0   <= REM_W'(pi.mag0);
      s[0].r1   <= REM_W'(pi.mag1);
      s[0].q0   <= '0;
      s[0].q1   <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    dstage_t nx;
    logic [REM_W-1:0] dsh;

    always_comb begin
      nx  = s[k];
      dsh = REM_W'(s[k].dmag) << B;
      if (s[k].r0 >= dsh) begin
        nx.r0    = s[k].r0 - dsh;
        nx.q0[B] = 1'b1;
      end
      if (s[k].r1 >= dsh) begin
        nx.r1    = s[k].r1 - dsh;
        nx.q1[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        s[k+1].valid <= 1'b0;
      end else if (st.adv) begin
        s[k+1].valid <= nx.valid;
      end
      if (st.adv) begin
        s[k+1].meta <= nx.meta;
        s[k+1].sn0  <= nx.sn0;
        s[k+1].sn1  <= nx.sn1;
        s[k+1].sd   <= nx.sd;
        s[k+1].dz   <= nx.dz;
        s[k+1].ov0  <= nx.ov0;
        s[k+1].ov1  <= nx.ov1;
        s[k+1].dmag <= nx.dmag;
        s[k+1].r0   <= nx.r0;
        s[k+1].r1   <= nx.r1;
        s[k+1].q0   <= nx.q0;
        s[k+1].q1   <= nx.q1;
      end
    end
  end

  assign dq = s[QW];

endmodule

// File: rtl/core/svc_carve.sv
// Back of the pipeline: view test, pixel memory, grid read-modify-write with
// forwarding, clearing pass and output register. Depends on svc_pkg, svc_if.
module svc_carve (
  input  logic              clk,
  input  logic              rst,
  input  svc_pkg::cfg_t     cfg,
  input  svc_pkg::dstage_t  dq,
  output svc_pkg::status_t  st,
  svc_out_if.source         results
);
  import svc_pkg::*;

  logic adv, clearing;
  logic [GRID_AW-1:0] ccnt;

  logic vv, vview, vpwe;
  meta_t vm;
  logic [PIX_AW-1:0] vpaddr;

  logic pv, pview;
  meta_t pm;
  logic [16:0] prd;

  logic av, aview;
  meta_t am;
  logic signed [VAL_W-1:0] ad, grd;

  logic cv, cview, cupd;
  logic [GRID_AW-1:0] caddr;
  logic signed [VAL_W-1:0] cval;

  logic signed [VAL_W-1:0] pd_next, old, newv;
  logic [LIM_W-1:0] cl, rl;
  logic neg0, neg1, col_ok, row_ok, view_next, pwe_next;
  logic acarve, lower, ares, gwe;
  logic [GRID_AW-1:0] gwa;
  logic signed [VAL_W-1:0] gwd;
  logic [PIX_AW-1:0] paddr_next;

  logic [16:0] pmem [PIX_DEPTH];
  logic signed [VAL_W-1:0] gmem [GRID_CELLS];

  assign adv = !cv || results.ready;
  assign st.adv = adv;
  assign st.clearing = clearing;

  // View test and pixel address
  always_comb begin
    cl = (LIM_W'(cfg.image_cols) < LIM_W'(MAX_COLS)) ? LIM_W'(cfg.image_cols)
                                                      : LIM_W'(MAX_COLS);
    rl = (LIM_W'(cfg.image_rows) < LIM_W'(MAX_ROWS)) ? LIM_W'(cfg.image_rows)
                                                      : LIM_W'(MAX_ROWS);
    neg0 = (dq.sn0 ^ dq.sd) && (dq.q0 != '0);
    neg1 = (dq.sn1 ^ dq.sd) && (dq.q1 != '0);
    col_ok = !dq.ov0 && !neg0 && (LIM_W'(dq.q0) < cl);
    row_ok = !dq.ov1 && !neg1 && (LIM_W'(dq.q1) < rl);
    view_next = (dq.meta.kind == KIND_CARVE) && !dq.dz && col_ok && row_ok;
    pwe_next = (dq.meta.kind == KIND_PIXEL) &&
               (LIM_W'(dq.meta.pixel_col) < LIM_W'(MAX_COLS)) &&
               (LIM_W'(dq.meta.pixel_row) < LIM_W'(MAX_ROWS));
    if (dq.meta.kind == KIND_PIXEL) begin
      paddr_next = PIX_AW'(dq.meta.pixel_row) * PIX_AW'(MAX_COLS) +
                   PIX_AW'(dq.meta.pixel_col);
    end else begin
      paddr_next = PIX_AW'(dq.q1) * PIX_AW'(MAX_COLS) + PIX_AW'(dq.q0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vv <= 1'b0;
    end else if (adv) begin
      vv <= dq.valid;
    end
    if (adv) begin
      vm     <= dq.meta;
      vview  <= view_next;
      vpwe   <= pwe_next;
      vpaddr <= paddr_next;
    end
  end

  // Pixel memory: loads write here, in order with the carves that read
  always_ff @(posedge clk) begin
    if (adv) begin
      if (vv && vpwe) begin
        pmem[vpaddr] <= {vm.pixel_distance, vm.pixel_inside};
      end
      prd <= pmem[vpaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (adv) begin
      pv <= vv;
    end
    if (adv) begin
      pm    <= vm;
      pview <= vview;
    end
  end

  // Distance: negate outside the mask, miss value out of view
  always_comb begin
    if (!pview) begin
      pd_next = MISS_VALUE;
    end else if (prd[0]) begin
      pd_next = $signed({1'b0, prd[16:1]});
    end else begin
      pd_next = -$signed({1'b0, prd[16:1]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
    end else if (adv) begin
      av <= pv;
    end
    if (adv) begin
      am    <= pm;
      aview <= pview;
      ad    <= pd_next;
    end
  end

  // Grid update; take the value just written when the previous beat hit
  // the same cell, since the memory read missed that write
  always_comb begin
    old    = (cv && caddr == am.gaddr) ? cval : grd;
    acarve = av && am.vox_ok && am.kind == KIND_CARVE;
    lower  = acarve && (ad < old);
    newv   = lower ? ad : old;
    ares   = av && am.vox_ok && (am.kind == KIND_CARVE || am.kind == KIND_READ);
    if (clearing) begin
      gwe = 1'b1;
      gwa = ccnt;
      gwd = CLEAR_VALUE;
    end else begin
      gwe = adv && lower;
      gwa = am.gaddr;
      gwd = ad;
    end
  end

  always_ff @(posedge clk) begin
    if (gwe) begin
      gmem[gwa] <= gwd;
    end
    if (adv) begin
      grd <= gmem[pm.gaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      ccnt     <= '0;
    end else if (clearing) begin
      ccnt <= ccnt + 1'b1;
      if (ccnt == GRID_AW'(GRID_CELLS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
    end else if (adv) begin
      cv <= ares;
    end
    if (adv) begin
      caddr <= am.gaddr;
      cval  <= newv;
      cview <= aview && acarve;
      cupd  <= lower;
    end
  end

  assign results.valid         = cv;
  assign results.voxel_address = 18'(caddr);
  assign results.voxel_value   = cval;
  assign results.in_view       = cview;
  assign results.updated       = cupd;

`ifndef ASSERT_OFF
  a_no_result_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !cv && !av)
    else $error("pipeline active during grid clear");
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    (cv && cupd && !cview) |-> cval == MISS_VALUE)
    else $error("out-of-view carve stored a value other than the miss value");
  a_lowered_below_clear: assert property (@(posedge clk) disable iff (rst)
    (cv && cupd) |-> cval < CLEAR_VALUE)
    else $error("lowered value not below clear value");
  a_view_only_carve: assert property (@(posedge clk) disable iff (rst)
    (adv && av && am.kind != KIND_CARVE) |=> !cview)
    else $error("in_view set on a read result");
`endif

endmodule

// File: tb/sv/silhouette_voxel_carver_tb.sv
// Self-checking testbench for silhouette_voxel_carver: camera loads, carves and reads,
// checked beat by beat against an in-bench projection and grid predictor.
// Depends on svc_pkg, svc_if and the RTL of the block.
module silhouette_voxel_carver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import svc_pkg::*;

  typedef struct {
    logic [1:0]         kind;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic [9:0]         pixel_col;
    logic [8:0]         pixel_row;
    logic [15:0]        pixel_distance;
    logic               pixel_inside;
    logic [5:0]         vx;
    logic [5:0]         vy;
    logic [5:0]         vz;
  } beat_t;

  typedef struct {
    logic [17:0]        addr;
    logic signed [16:0] value;
    logic               in_view;
    logic               updated;
  } voxel_result_t;

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [31:0] cfg_data;

  svc_in_if  items_if();
  svc_out_if results_if();

  silhouette_voxel_carver i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .items(items_if), .results(results_if)
  );

  // predictor state
  longint start_pos[3];
  longint step_len[3];
  longint img_cols, img_rows;
  longint proj_mat[12];
  logic [16:0] pixel_mem [int];
  logic signed [16:0] grid_mem [int];
  voxel_result_t pending_results[$];

  int errors = 0;
  int hold_off = 0;
  bit stall_on = 1;
  bit gap_on = 1;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("[silhouette_voxel_carver] ERROR");
    $finish;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint row_sum(int r, longint px, longint py, longint pz);
    return ((proj_mat[r*4] * px) >>> 2) + ((proj_mat[r*4+1] * py) >>> 2) +
           ((proj_mat[r*4+2] * pz) >>> 2) + proj_mat[r*4+3] * 16384;
  endfunction

  // Project a voxel; return 1 and the pixel address when it lands in the image.
  function automatic bit project_voxel(int x, int y, int z, output int paddr);
    longint px, py, pz, den, c, r, cl, rl;
    paddr = 0;
    px = sat32(start_pos[0] + x * step_len[0]);
    py = sat32(start_pos[1] + y * step_len[1]);
    pz = sat32(start_pos[2] + z * step_len[2]);
    den = row_sum(2, px, py, pz);
    if (den == 0) return 0;
    c = row_sum(0, px, py, pz) / den;
    r = row_sum(1, px, py, pz) / den;
    cl = (img_cols < MAX_COLS) ? img_cols : MAX_COLS;
    rl = (img_rows < MAX_ROWS) ? img_rows : MAX_ROWS;
    if (c < 0 || r < 0 || c >= cl || r >= rl) return 0;
    paddr = int'(r * MAX_COLS + c);
    return 1;
  endfunction

  function automatic void apply_beat(beat_t b);
    voxel_result_t res;
    int a, paddr, d, old;
    bit view;
    case (b.kind)
      KIND_COEF: if (b.coef_index < MAT_ENTRIES) proj_mat[b.coef_index] = longint'(b.coef_value);
      KIND_PIXEL: pixel_mem[b.pixel_row * MAX_COLS + b.pixel_col] = {b.pixel_inside, b.pixel_distance};
      default: begin
        a = b.vx * GRID_DIM * GRID_DIM + b.vy * GRID_DIM + b.vz;
        old = grid_mem.exists(a) ? int'(grid_mem[a]) : int'(CLEAR_VALUE);
        res.addr = a[17:0];
        res.in_view = 0;
        res.updated = 0;
        if (b.kind == KIND_CARVE) begin
          view = project_voxel(b.vx, b.vy, b.vz, paddr);
          d = int'(MISS_VALUE);
          if (view) begin
            d = int'(pixel_mem[paddr][15:0]);
            if (!pixel_mem[paddr][16]) d = -d;
          end
          res.in_view = view;
          if (d < old) begin
            old = d;
            grid_mem[a] = d[16:0];
            res.updated = 1;
          end
        end
        res.value = old[16:0];
        pending_results.push_back(res);
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    voxel_result_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result addr=%0d value=%0d", $time,
                 results_if.voxel_address, results_if.voxel_value);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (results_if.voxel_address !== want.addr) begin
          $display("%0t: voxel_address expected %0d actual %0d", $time, want.addr,
                   results_if.voxel_address);
          errors++;
        end
        if (results_if.voxel_value !== want.value) begin
          $display("%0t: voxel_value at %0d expected %0d actual %0d", $time, want.addr,
                   want.value, results_if.voxel_value);
          errors++;
        end
        if (results_if.in_view !== want.in_view) begin
          $display("%0t: in_view at %0d expected %0b actual %0b", $time, want.addr,
                   want.in_view, results_if.in_view);
          errors++;
        end
        if (results_if.updated !== want.updated) begin
          $display("%0t: updated at %0d expected %0b actual %0b", $time, want.addr,
                   want.updated, results_if.updated);
          errors++;
        end
      end
    end
  end

  // result-side backpressure; hold_off counts down a long stall
  initial begin
    int r;
    results_if.ready <= 0;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (hold_off > 0) begin
        results_if.ready <= 0;
        hold_off--;
      end else if (!stall_on) begin
        results_if.ready <= 1;
      end else if (r < 2) begin
        hold_off = $urandom_range(8, 40);
        results_if.ready <= 0;
      end else begin
        results_if.ready <= (r < 75);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gap_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_beat(beat_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      items_if.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    items_if.valid          <= 1;
    items_if.kind           <= b.kind;
    items_if.coef_index     <= b.coef_index;
    items_if.coef_value     <= b.coef_value;
    items_if.pixel_col      <= b.pixel_col;
    items_if.pixel_row      <= b.pixel_row;
    items_if.pixel_distance <= b.pixel_distance;
    items_if.pixel_inside   <= b.pixel_inside;
    items_if.voxel_x        <= b.vx;
    items_if.voxel_y        <= b.vy;
    items_if.voxel_z        <= b.vz;
    do @(posedge clk); while (!items_if.ready);
    apply_beat(b);
  endtask

  function automatic beat_t noise_beat(logic [1:0] kind);
    beat_t b;
    b.kind = kind;
    b.coef_index = 4'($urandom_range(0, 15));
    b.coef_value = $urandom;
    b.pixel_col = 10'($urandom);
    b.pixel_row = 9'($urandom);
    b.pixel_distance = 16'($urandom);
    b.pixel_inside = 1'($urandom);
    b.vx = 6'($urandom);
    b.vy = 6'($urandom);
    b.vz = 6'($urandom);
    return b;
  endfunction

  task automatic load_coef(int idx, logic signed [31:0] v);
    beat_t b;
    b = noise_beat(KIND_COEF);
    b.coef_index = 4'(idx);
    b.coef_value = v;
    send_beat(b);
  endtask

  task automatic load_pixel(int paddr, logic [15:0] pix_dist, logic pix_in);
    beat_t b;
    b = noise_beat(KIND_PIXEL);
    b.pixel_col = 10'(paddr % MAX_COLS);
    b.pixel_row = 9'(paddr / MAX_COLS);
    b.pixel_distance = pix_dist;
    b.pixel_inside = pix_in;
    send_beat(b);
  endtask

  // Carve, first loading the target pixel if it was never written.
  task automatic carve(int x, int y, int z);
    beat_t b;
    int paddr;
    b = noise_beat(KIND_CARVE);
    b.vx = 6'(x);
    b.vy = 6'(y);
    b.vz = 6'(z);
    if (project_voxel(b.vx, b.vy, b.vz, paddr) && !pixel_mem.exists(paddr))
      load_pixel(paddr, 16'($urandom), 1'($urandom));
    send_beat(b);
  endtask

  task automatic read_voxel(int x, int y, int z);
    beat_t b;
    b = noise_beat(KIND_READ);
    b.vx = 6'(x);
    b.vy = 6'(y);
    b.vz = 6'(z);
    send_beat(b);
  endtask

  // Entry of a camera that mostly looks at the grid; now and then pure noise.
  function automatic logic signed [31:0] camera_coef(int idx);
    if ($urandom_range(0, 11) == 0) return $urandom;
    case (idx)
      0, 5:  return 4096 * $urandom_range(1, 16) + $urandom_range(0, 4095);
      1, 2, 4, 6: return $urandom_range(0, 3) == 0 ? $signed($urandom_range(0, 2047)) - 1024 : 0;
      3, 7:  return $signed($urandom_range(0, 4096 * 300)) - 4096 * 40;
      8, 9:  return 0;
      10:    return $urandom_range(0, 3) == 0 ? $urandom_range(0, 64) : 0;
      default: return 4096 * $urandom_range(1, 4);
    endcase
  endfunction

  task automatic load_camera();
    for (int i = 0; i < MAT_ENTRIES; i++) load_coef(i, camera_coef(i));
  endtask

  // Drop valid now, drain all results, then let the pipeline empty.
  task automatic quiesce();
    items_if.valid <= 0;
    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 0;
    if (idx <= CFG_START_Z) start_pos[idx] = longint'($signed(data));
    else if (idx <= CFG_STEP_Z) step_len[idx - CFG_STEP_X] = longint'(data[30:0]);
    else if (idx == CFG_COLS) img_cols = data[10:0];
    else img_rows = data[9:0];
  endtask

  task automatic set_geometry(logic [31:0] sx, sy, sz, dx, dy, dz, cols, rows);
    quiesce();
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_START_Z, sz);
    write_reg(CFG_STEP_X, dx);
    write_reg(CFG_STEP_Y, dy);
    write_reg(CFG_STEP_Z, dz);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_ROWS, rows);
  endtask

  task automatic test_directed();
    // straight-on camera: column = x, row = y
    for (int i = 0; i < MAT_ENTRIES; i++)
      load_coef(i, (i == 0 || i == 5 || i == 11) ? 4096 : 0);
    load_coef(12, 32'h7FFFFFFF);
    load_coef(15, 32'h80000000);
    load_pixel(0, 16'hFFFF, 1);
    carve(0, 0, 0);
    carve(0, 0, 0);
    load_pixel(1 * MAX_COLS + 63, 16'hFFFF, 0);
    carve(63, 1, 63);
    read_voxel(63, 1, 63);
    read_voxel(17, 40, 5);
    // half a pixel left of zero truncates to column zero
    load_coef(3, -2048);
    carve(0, 2, 9);
    // whole pixels left of zero miss the image
    load_coef(3, -4096 * 5);
    carve(1, 3, 4);
    // zero denominator
    load_coef(11, 0);
    carve(5, 5, 5);
    carve(63, 63, 63);
    load_coef(3, 0);
    load_coef(11, 4096);
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 62) carve($urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 63));
      else if (r < 70) carve($urandom, $urandom, $urandom);
      else if (r < 82) read_voxel($urandom_range(0, 15), $urandom, $urandom);
      else if (r < 90) send_beat(noise_beat(KIND_PIXEL));
      else if (r < 97) load_coef($urandom_range(0, 11), camera_coef($urandom_range(0, 11)));
      else send_beat(noise_beat(KIND_COEF));
    end
  endtask

  task automatic test_pressure();
    quiesce();
    hold_off = 600;
    gap_on = 0;
    test_random(80);
    gap_on = 1;
  endtask

  initial begin
    rst <= 1;
    cfg_we <= 0;
    cfg_index <= CFG_START_X;
    cfg_data <= 0;
    items_if.valid <= 0;
    items_if.kind <= KIND_COEF;
    items_if.coef_index <= 0;
    items_if.coef_value <= 0;
    items_if.pixel_col <= 0;
    items_if.pixel_row <= 0;
    items_if.pixel_distance <= 0;
    items_if.pixel_inside <= 0;
    items_if.voxel_x <= 0;
    items_if.voxel_y <= 0;
    items_if.voxel_z <= 0;
    start_pos = '{0, 0, 0};
    step_len = '{65536, 65536, 65536};
    img_cols = 640;
    img_rows = 480;
    foreach (proj_mat[i]) proj_mat[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 0;

    test_directed();
    load_camera();
    test_random(250);

    stall_on = 0;
    gap_on = 0;
    test_random(150);
    stall_on = 1;
    gap_on = 1;

    set_geometry(0, 0, 0, 65536, 65536, 65536, 1, 1);
    load_camera();
    test_random(150);

    set_geometry(0, 0, 0, 32768, 32768, 131072, 1024, 512);
    load_camera();
    test_random(250);
    test_pressure();

    // positions at both ends of the Q16.16 range, saturated at the top end
    set_geometry(32'h7FFF0000, 32'h80000000, 32'h7FFFFFFF,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1024, 512);
    load_camera();
    test_random(120);

    set_geometry($urandom_range(0, 65536 * 8) - 65536 * 4, $urandom_range(0, 65536 * 8),
                 $urandom, $urandom_range(16384, 196608), $urandom_range(16384, 196608),
                 $urandom, $urandom_range(1, 1024), $urandom_range(1, 512));
    load_camera();
    test_random(300);

    quiesce();
    if (errors == 0) begin
      $display("[silhouette_voxel_carver] OK");
    end else begin
      $display("[silhouette_voxel_carver] ERROR");
    end
    $finish;
  end
endmodule

// File: silhouette_voxel_carver.f
rtl/core/svc_pkg.sv
rtl/core/svc_if.sv
rtl/core/svc_proj.sv
rtl/core/svc_div.sv
rtl/core/svc_carve.sv
rtl/core/silhouette_voxel_carver.sv
tb/sv/silhouette_voxel_carver_tb.sv
